/* design/tls_sni_extractor_unit_macros.svh */
// Assertion macros used by the SNI extractor top level.
`ifndef TLS_SNI_EXTRACTOR_UNIT_MACROS_SVH
`define TLS_SNI_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TSX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TSX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* design/tlssni_pkg.sv */
// Types and constants of the TLS SNI extractor.
`default_nettype none
package tlssni_pkg;

  localparam int POSITION_BITS = 16;
  localparam int POS_W = POSITION_BITS + 1;
  // Wide enough for offset + 16-bit length + small constants.
  localparam int CALC_W = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 2;

  localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};

  localparam logic [7:0] REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;

  localparam logic [POS_W-1:0] OFF_REC_TYPE = POS_W'(0);
  localparam logic [POS_W-1:0] OFF_LEN_HI   = POS_W'(3);
  localparam logic [POS_W-1:0] OFF_LEN_LO   = POS_W'(4);
  localparam logic [POS_W-1:0] OFF_HS_TYPE  = POS_W'(5);
  localparam logic [POS_W-1:0] SID_OFFSET   = POS_W'(43);

  localparam logic [CALC_W-1:0] REC_HDR_LEN   = CALC_W'(5);
  localparam logic [CALC_W-1:0] SID_OFF_C     = CALC_W'(43);
  // Server name list length (2) and name type (1) sit before the name length.
  localparam logic [CALC_W-1:0] NAME_HDR_SKIP = CALC_W'(4);

  typedef enum logic [2:0] {
    ST_NAME   = 3'd0,
    ST_DONE   = 3'd1,
    ST_NOT_HS = 3'd2,
    ST_NOT_CH = 3'd3,
    ST_LENGTH = 3'd4,
    ST_NO_SNI = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_CIPH_HI = 4'd1,
    PH_CIPH_LO = 4'd2,
    PH_COMP    = 4'd3,
    PH_EXTL_HI = 4'd4,
    PH_EXTL_LO = 4'd5,
    PH_ID_HI   = 4'd6,
    PH_ID_LO   = 4'd7,
    PH_ELEN_HI = 4'd8,
    PH_ELEN_LO = 4'd9,
    PH_NLEN_HI = 4'd10,
    PH_NLEN_LO = 4'd11,
    PH_NAME    = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    status_t    status;
    logic       run_end;
  } res_t;

endpackage
`default_nettype wire

/* design/tlssni_parse_core.sv */
// Per-byte ClientHello parse state and its per-byte update.
`default_nettype none
module tlssni_parse_core
  import tlssni_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] byte_in,
  input  logic       last_in,
  output logic       res_hit,
  output res_t       res
);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CALC_W-1:0] lim_r, lim_nxt;
  logic [7:0]        acc_r, acc_nxt;
  logic [CALC_W-1:0] nfp_r, nfp_nxt;
  logic [CALC_W-1:0] ext_end_r, ext_end_nxt;
  logic [15:0]       ext_id_r, ext_id_nxt;
  logic [15:0]       name_rem_r, name_rem_nxt;
  logic              decided_r, decided_nxt;

  logic [CALC_W-1:0] pos_c, v_c, b_c, pos_v, pos_1b, pos_1v;
  logic [15:0]       v16, rem_dec;

  assign v16     = {acc_r, byte_in};
  assign pos_c   = CALC_W'(pos_r);
  assign v_c     = CALC_W'(v16);
  assign b_c     = CALC_W'(byte_in);
  assign pos_v   = pos_c + v_c;
  assign pos_1b  = pos_c + b_c + CALC_W'(1);
  assign pos_1v  = pos_v + CALC_W'(1);
  assign rem_dec = name_rem_r - 16'd1;

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    lim_nxt      = lim_r;
    acc_nxt      = acc_r;
    nfp_nxt      = nfp_r;
    ext_end_nxt  = ext_end_r;
    ext_id_nxt   = ext_id_r;
    name_rem_nxt = name_rem_r;
    decided_nxt  = decided_r;
    res_hit        = 1'b0;
    res.name_char  = 8'd0;
    res.char_valid = 1'b0;
    res.status     = ST_NAME;
    res.run_end    = 1'b0;

    if (!decided_r) begin
      if (pos_r >= POS_LIMIT) begin
        res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
      end else if (phase_r == PH_HEADER) begin
        if (pos_r == OFF_REC_TYPE && byte_in != REC_HANDSHAKE) begin
          res_hit = 1'b1; res.status = ST_NOT_HS; res.run_end = 1'b1; decided_nxt = 1'b1;
        end else if (pos_r == OFF_LEN_HI) begin
          acc_nxt = byte_in;
        end else if (pos_r == OFF_LEN_LO) begin
          lim_nxt = v_c + REC_HDR_LEN;
        end else if (pos_r == OFF_HS_TYPE && byte_in != HS_CLIENT_HELLO) begin
          res_hit = 1'b1; res.status = ST_NOT_CH; res.run_end = 1'b1; decided_nxt = 1'b1;
        end else if (pos_r == SID_OFFSET) begin
          if (b_c + SID_OFF_C + CALC_W'(2) > lim_r) begin
            res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
          end else begin
            nfp_nxt   = SID_OFF_C + CALC_W'(1) + b_c;
            phase_nxt = PH_CIPH_HI;
          end
        end
      end else if (pos_c == nfp_r) begin
        nfp_nxt = pos_c + CALC_W'(1);
        unique case (phase_r)
          PH_CIPH_HI: begin acc_nxt = byte_in; phase_nxt = PH_CIPH_LO; end
          PH_EXTL_HI: begin acc_nxt = byte_in; phase_nxt = PH_EXTL_LO; end
          PH_ID_HI:   begin acc_nxt = byte_in; phase_nxt = PH_ID_LO;   end
          PH_ELEN_HI: begin acc_nxt = byte_in; phase_nxt = PH_ELEN_LO; end
          PH_NLEN_HI: begin acc_nxt = byte_in; phase_nxt = PH_NLEN_LO; end
          PH_CIPH_LO: begin
            if (pos_v > lim_r) begin
              res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
            end else begin
              nfp_nxt   = pos_1v;
              phase_nxt = PH_COMP;
            end
          end
          PH_COMP: begin
            if (pos_1b > lim_r) begin
              res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
            end else begin
              nfp_nxt   = pos_1b;
              phase_nxt = PH_EXTL_HI;
            end
          end
          PH_EXTL_LO: begin
            // Bound counts the two-byte length field itself.
            if (pos_v > lim_r + CALC_W'(1)) begin
              res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
            end else begin
              ext_end_nxt = pos_1v;
              phase_nxt   = PH_ID_HI;
              if (v16 == 16'd0) begin
                res_hit = 1'b1; res.status = ST_NO_SNI; res.run_end = 1'b1; decided_nxt = 1'b1;
              end
            end
          end
          PH_ID_LO: begin
            ext_id_nxt = v16;
            phase_nxt  = PH_ELEN_HI;
          end
          PH_ELEN_LO: begin
            if (ext_id_r == 16'd0) begin
              nfp_nxt   = pos_c + NAME_HDR_SKIP;
              phase_nxt = PH_NLEN_HI;
            end else begin
              nfp_nxt   = pos_1v;
              phase_nxt = PH_ID_HI;
              if (pos_1v >= ext_end_r) begin
                res_hit = 1'b1; res.status = ST_NO_SNI; res.run_end = 1'b1; decided_nxt = 1'b1;
              end
            end
          end
          PH_NLEN_LO: begin
            name_rem_nxt = v16;
            if (v16 == 16'd0) begin
              res_hit = 1'b1; res.status = ST_DONE; res.run_end = 1'b1; decided_nxt = 1'b1;
            end else begin
              phase_nxt = PH_NAME;
            end
          end
          PH_NAME: begin
            name_rem_nxt   = rem_dec;
            res_hit        = 1'b1;
            res.name_char  = byte_in;
            res.char_valid = 1'b1;
            if (rem_dec == 16'd0) begin
              res.status = ST_DONE; res.run_end = 1'b1; decided_nxt = 1'b1;
            end
          end
          default: begin
            res_hit = 1'b1; res.status = ST_LENGTH; res.run_end = 1'b1; decided_nxt = 1'b1;
          end
        endcase
      end
    end

    if (last_in) begin
      // Undecided at packet end: replace any name byte with a length error.
      if (!decided_nxt) begin
        res_hit        = 1'b1;
        res.name_char  = 8'd0;
        res.char_valid = 1'b0;
        res.status     = ST_LENGTH;
        res.run_end    = 1'b1;
      end
      pos_nxt      = '0;
      phase_nxt    = PH_HEADER;
      lim_nxt      = '0;
      acc_nxt      = '0;
      nfp_nxt      = '0;
      ext_end_nxt  = '0;
      ext_id_nxt   = '0;
      name_rem_nxt = '0;
      decided_nxt  = 1'b0;
    end else if (pos_r < POS_LIMIT) begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      phase_r    <= PH_HEADER;
      lim_r      <= '0;
      acc_r      <= '0;
      nfp_r      <= '0;
      ext_end_r  <= '0;
      ext_id_r   <= '0;
      name_rem_r <= '0;
      decided_r  <= 1'b0;
    end else if (step) begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      lim_r      <= lim_nxt;
      acc_r      <= acc_nxt;
      nfp_r      <= nfp_nxt;
      ext_end_r  <= ext_end_nxt;
      ext_id_r   <= ext_id_nxt;
      name_rem_r <= name_rem_nxt;
      decided_r  <= decided_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/tls_sni_extractor_unit.sv */
// Top level of the TLS ClientHello server-name extractor.
//
// Usage:
//   The input channel carries one TCP payload byte per transaction, from
//   offset zero, with in_packet_end high on the packet's final byte. The
//   output channel carries host name bytes (status 0, last one status 1 with
//   run_end) or one status transaction per failed packet.
//   A transaction is taken on a rising edge with valid high and stall low.
//
// Throughput and order:
//   One byte per clock while no result waits on out_stall. An accepted byte
//   is held in the input register and parsed from there; its result then
//   loads the output register, which drives out_valid.
//   The parse update (a counter compare and an add on the bound) sets the cycle.
//
// Stall and reset:
//   While out_stall holds a result, the input register keeps its byte only
//   if that byte produces a result of its own; bytes that produce nothing
//   keep flowing. rst_n (synchronous, active low) empties both registers and
//   returns the parser to the record header phase at offset zero.
`default_nettype none
`include "tls_sni_extractor_unit_macros.svh"
module tls_sni_extractor_unit
  import tlssni_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_payload_byte,
  input  logic       in_packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_name_char,
  output logic       out_char_valid,
  output logic [2:0] out_status,
  output logic       out_run_end
);

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  res_t       out_res_r;

  logic       res_hit;
  res_t       res;
  logic       out_free, s1_adv, in_take;

  // Parse update for the byte held in the input register.
  tlssni_parse_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .byte_in (s1_byte_r),
    .last_in (s1_end_r),
    .res_hit (res_hit),
    .res     (res)
  );

  // Advance the held byte unless its result has nowhere to go.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!res_hit || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && res_hit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_payload_byte;
      s1_end_r  <= in_packet_end;
    end
    if (s1_adv && res_hit) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_name_char  = out_res_r.name_char;
  assign out_char_valid = out_res_r.char_valid;
  assign out_status     = out_res_r.status;
  assign out_run_end    = out_res_r.run_end;

  `TSX_ASSERT_IMP(a_stall_needs_item, in_stall, s1_valid_r, "input stalled with empty stage")
  `TSX_ASSERT_IMP(a_mid_name_byte, out_valid && !out_run_end,
                  out_char_valid && out_status == ST_NAME, "non-final result is not a name byte")
  `TSX_ASSERT_IMP(a_status_is_final, out_valid && !out_char_valid,
                  out_run_end && out_status != ST_NAME, "status result not final")
  `TSX_ASSERT_NXT(a_stage_drains, s1_valid_r && !in_stall && !in_valid, !s1_valid_r,
                  "input stage did not drain")

endmodule
`default_nettype wire
